>>> rtl/oat_pkg.sv
// ----------------------------------------------------------------------------
// oat_pkg
// Types and codes shared by the ordered admission throttle.
// ----------------------------------------------------------------------------
package oat_pkg;

    localparam int LINK_W  = 6;
    localparam int COUNT_W = 6;
    localparam int TASK_W  = 5;

    localparam logic [LINK_W-1:0] NIL_LINK = 6'd63;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_THR  = 2'd1;
    localparam logic [1:0] ST_GONE = 2'd2;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_PRESENT = 2'd1;
    localparam logic [1:0] ERR_ABSENT  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TASK_W-1:0] task_id;
    } item_t;

    typedef struct packed {
        logic [TASK_W-1:0]  notice_task;
        logic [1:0]         new_state;
        logic               is_summary;
        logic [COUNT_W-1:0] running_count;
        logic [COUNT_W-1:0] throttled_count;
        logic [1:0]         error_code;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_LINK,
        S_APP_TAIL,
        S_REM_FIX,
        S_REM_BND,
        S_REB,
        S_REB_NEXT,
        S_REB_PREV,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_SUMMARY
    } fsm_t;

endpackage

>>> rtl/ordered_admission_throttle_unit.sv
// ----------------------------------------------------------------------------
// ordered_admission_throttle_unit
// Ordered task table with a running limit; the front tasks run, the rest wait.
// ----------------------------------------------------------------------------
// Usage:
//   An item (append, remove or rebalance) is taken when start is high and
//   busy is low. The block then walks its link memories and emits one beat
//   per task whose state changed, in order of first change, followed by a
//   summary beat with last set. Every beat appears on result for exactly one
//   cycle with result_strobe high; the receiver cannot stall it.
//   The user must write the limit through cfg_we/cfg_wdata only while the
//   block is idle; the block itself does not enforce this.
// Phases:
//   Operation phase for append and remove (none on error or rebalance), then
//   rebalance, which promotes tasks past the boundary or demotes tasks back
//   from the tail or boundary, then emission of the logged changes and the summary.
//   The single read port of each link memory sets the pace of the walk.
// Reset:
//   All tasks absent, limit 32, no beats pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_admission_throttle_unit #(
    parameter int MAX_TASKS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  oat_pkg::item_t          item,
    input  logic                    cfg_we,
    input  logic [5:0]              cfg_wdata,
    output logic                    result_strobe,
    output oat_pkg::result_t        result
);
    import oat_pkg::*;

    localparam int DEPTH = (MAX_TASKS < 32) ? MAX_TASKS : 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsm_t state_reg, state_next;

    logic [TASK_W-1:0]  tid_reg, tid_next;
    logic [1:0]         err_reg, err_next;
    logic [1:0]         tid_st_reg, tid_st_next;
    logic               prom_reg, prom_next;
    logic [COUNT_W-1:0] limit_reg;
    logic [LINK_W-1:0]  last_reg, last_next;
    logic [LINK_W-1:0]  bnd_reg, bnd_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   emit_idx_reg, emit_idx_next;
    logic [1:0]         status_reg [DEPTH];
    logic [DEPTH-1:0]   logged_reg;
    logic               strobe_reg, strobe_next;
    result_t            result_reg, result_next;

    logic [LINK_W-1:0]  next_mem [DEPTH];
    logic [LINK_W-1:0]  prev_mem [DEPTH];
    logic [IDX_W+1:0]   log_mem  [DEPTH];
    logic [LINK_W-1:0]  next_rd_reg, prev_rd_reg;
    logic [IDX_W+1:0]   log_rd_reg;

    logic [IDX_W-1:0]   next_raddr, prev_raddr, next_waddr, prev_waddr, log_raddr;
    logic               next_we, prev_we;
    logic [LINK_W-1:0]  next_wdata, prev_wdata;

    logic               chg_en;
    logic [IDX_W-1:0]   chg_task;
    logic [1:0]         chg_state;
    logic [IDX_W-1:0]   stat_addr;
    logic [1:0]         stat_rd;
    logic               log_we;
    logic               clear_log;
    logic               tid_ok;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   tid_idx;
    logic [IDX_W-1:0]   log_task;
    logic [COUNT_W-1:0] thr_count;

    assign in_idx    = item.task_id[IDX_W-1:0];
    assign tid_idx   = tid_reg[IDX_W-1:0];
    assign log_task  = log_rd_reg[IDX_W+1:2];
    assign stat_rd   = status_reg[stat_addr];
    assign log_we    = chg_en && !logged_reg[chg_task];
    assign tid_ok    = (7'(item.task_id) < 7'(MAX_TASKS));
    assign thr_count = total_reg - run_reg;
    assign busy      = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        tid_next      = tid_reg;
        err_next      = err_reg;
        tid_st_next   = tid_st_reg;
        prom_next     = prom_reg;
        last_next     = last_reg;
        bnd_next      = bnd_reg;
        run_next      = run_reg;
        total_next    = total_reg;
        emit_idx_next = emit_idx_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        next_raddr    = bnd_reg[IDX_W-1:0];
        prev_raddr    = bnd_reg[IDX_W-1:0];
        next_we       = 1'b0;
        next_waddr    = tid_idx;
        next_wdata    = NIL_LINK;
        prev_we       = 1'b0;
        prev_waddr    = tid_idx;
        prev_wdata    = last_reg;
        log_raddr     = emit_idx_reg[IDX_W-1:0];
        chg_en        = 1'b0;
        chg_task      = tid_idx;
        chg_state     = ST_RUN;
        stat_addr     = tid_idx;
        clear_log     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                stat_addr  = in_idx;
                next_raddr = in_idx;
                prev_raddr = in_idx;
                if (start)
                begin
                    clear_log   = 1'b1;
                    tid_next    = item.task_id;
                    tid_st_next = stat_rd;
                    prom_next   = 1'b0;
                    err_next    = ERR_OK;
                    state_next  = S_REB;
                    if (item.kind == KIND_APPEND)
                    begin
                        if (!tid_ok)
                            err_next = ERR_ABSENT;
                        else if (stat_rd != ST_GONE)
                            err_next = ERR_PRESENT;
                        else
                            state_next = S_APP_LINK;
                    end
                    else if (item.kind == KIND_REMOVE)
                    begin
                        if (!tid_ok || stat_rd == ST_GONE)
                            err_next = ERR_ABSENT;
                        else
                            state_next = S_REM_FIX;
                    end
                end
            end
            S_APP_LINK:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                state_next = S_APP_TAIL;
            end
            S_APP_TAIL:
            begin
                if (last_reg != NIL_LINK)
                begin
                    next_we    = 1'b1;
                    next_waddr = last_reg[IDX_W-1:0];
                    next_wdata = LINK_W'(tid_reg);
                end
                last_next  = LINK_W'(tid_reg);
                total_next = total_reg + 1'b1;
                chg_en     = 1'b1;
                if (bnd_reg != NIL_LINK)
                    chg_state = ST_THR;
                else if (total_next > limit_reg)
                begin
                    bnd_next  = LINK_W'(tid_reg);
                    chg_state = ST_THR;
                end
                else
                    run_next = run_reg + 1'b1;
                state_next = S_REB;
            end
            S_REM_FIX:
            begin
                if (prev_rd_reg != NIL_LINK)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg[IDX_W-1:0];
                    next_wdata = next_rd_reg;
                end
                if (next_rd_reg != NIL_LINK)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_reg[IDX_W-1:0];
                    prev_wdata = prev_rd_reg;
                end
                else
                    last_next = prev_rd_reg;
                total_next = total_reg - 1'b1;
                if (tid_st_reg == ST_RUN)
                begin
                    if (bnd_reg != NIL_LINK)
                    begin
                        chg_en    = 1'b1;
                        chg_task  = bnd_reg[IDX_W-1:0];
                        chg_state = ST_RUN;
                        stat_addr = bnd_reg[IDX_W-1:0];
                        prom_next = 1'b1;
                    end
                    else if (run_reg != '0)
                        run_next = run_reg - 1'b1;
                end
                else if (LINK_W'(tid_reg) == bnd_reg)
                    bnd_next = next_rd_reg;
                state_next = S_REM_BND;
            end
            S_REM_BND:
            begin
                if (prom_reg)
                    bnd_next = next_rd_reg;
                chg_en     = 1'b1;
                chg_state  = ST_GONE;
                state_next = S_REB;
            end
            S_REB:
            begin
                if (run_reg < limit_reg && bnd_reg != NIL_LINK)
                begin
                    chg_en     = 1'b1;
                    chg_task   = bnd_reg[IDX_W-1:0];
                    stat_addr  = bnd_reg[IDX_W-1:0];
                    chg_state  = ST_RUN;
                    run_next   = run_reg + 1'b1;
                    state_next = S_REB_NEXT;
                end
                else if (run_reg > limit_reg)
                begin
                    if (bnd_reg != NIL_LINK)
                        state_next = S_REB_PREV;
                    else if (last_reg == NIL_LINK)
                        state_next = S_EMIT_RD;
                    else
                    begin
                        bnd_next  = last_reg;
                        chg_en    = 1'b1;
                        chg_task  = last_reg[IDX_W-1:0];
                        stat_addr = last_reg[IDX_W-1:0];
                        chg_state = ST_THR;
                        run_next  = run_reg - 1'b1;
                    end
                end
                else
                    state_next = S_EMIT_RD;
                if (state_next == S_EMIT_RD)
                begin
                    emit_idx_next = '0;
                    if (cnt_reg == '0)
                        state_next = S_SUMMARY;
                end
            end
            S_REB_NEXT:
            begin
                bnd_next   = next_rd_reg;
                state_next = S_REB;
            end
            S_REB_PREV:
            begin
                if (prev_rd_reg == NIL_LINK)
                begin
                    emit_idx_next = '0;
                    state_next    = (cnt_reg == '0) ? S_SUMMARY : S_EMIT_RD;
                end
                else
                begin
                    bnd_next   = prev_rd_reg;
                    chg_en     = 1'b1;
                    chg_task   = prev_rd_reg[IDX_W-1:0];
                    stat_addr  = prev_rd_reg[IDX_W-1:0];
                    chg_state  = ST_THR;
                    run_next   = run_reg - 1'b1;
                    state_next = S_REB;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                stat_addr = log_task;
                if (stat_rd != log_rd_reg[1:0])
                begin
                    strobe_next                 = 1'b1;
                    result_next.notice_task     = TASK_W'(log_task);
                    result_next.new_state       = stat_rd;
                    result_next.is_summary      = 1'b0;
                    result_next.running_count   = run_reg;
                    result_next.throttled_count = thr_count;
                    result_next.error_code      = ERR_OK;
                    result_next.last            = 1'b0;
                end
                emit_idx_next = emit_idx_reg + 1'b1;
                state_next    = (emit_idx_next == cnt_reg) ? S_SUMMARY : S_EMIT_RD;
            end
            S_SUMMARY:
            begin
                strobe_next                 = 1'b1;
                result_next.notice_task     = tid_reg;
                result_next.new_state       = ST_RUN;
                result_next.is_summary      = 1'b1;
                result_next.running_count   = run_reg;
                result_next.throttled_count = thr_count;
                result_next.error_code      = err_reg;
                result_next.last            = 1'b1;
                state_next                  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= 6'd32;
            last_reg     <= NIL_LINK;
            bnd_reg      <= NIL_LINK;
            run_reg      <= '0;
            total_reg    <= '0;
            cnt_reg      <= '0;
            logged_reg   <= '0;
            strobe_reg   <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
                status_reg[i] <= ST_GONE;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            bnd_reg    <= bnd_next;
            run_reg    <= run_next;
            total_reg  <= total_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (clear_log)
            begin
                logged_reg <= '0;
                cnt_reg    <= '0;
            end
            else if (log_we)
            begin
                logged_reg[chg_task] <= 1'b1;
                cnt_reg              <= cnt_reg + 1'b1;
            end
            if (chg_en)
                status_reg[chg_task] <= chg_state;
        end
    end

    // payload and item context
    always_ff @(posedge clk)
    begin
        tid_reg      <= tid_next;
        err_reg      <= err_next;
        tid_st_reg   <= tid_st_next;
        prom_reg     <= prom_next;
        emit_idx_reg <= emit_idx_next;
        result_reg   <= result_next;
    end

    // link memories and change log, registered read
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (log_we)
            log_mem[cnt_reg[IDX_W-1:0]] <= {chg_task, stat_rd};
        next_rd_reg <= next_mem[next_raddr];
        prev_rd_reg <= prev_mem[prev_raddr];
        log_rd_reg  <= log_mem[log_raddr];
    end

endmodule

>>> dv/oat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oat_checker
// Watches the item and result channels of the admission throttle, keeps its
// own copy of the task order and limit, predicts every result beat and
// compares each one field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module oat_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  oat_pkg::item_t   item,
    input  logic             cfg_we,
    input  logic [5:0]       cfg_wdata,
    input  logic             result_strobe,
    input  oat_pkg::result_t result,
    output int               errors,
    output int               pending
);
    import oat_pkg::*;

    localparam int NTASK = 32;

    logic [5:0] limit_q;
    logic [5:0] nxt [64];
    logic [5:0] prv [64];
    logic [1:0] status [64];
    logic [5:0] head_q;
    logic [5:0] tail_q;
    logic [5:0] bnd_q;
    logic [5:0] run_q;
    logic [5:0] total_q;

    logic [4:0] chg_task [$];
    logic [1:0] chg_state [$];
    logic [1:0] chg_prior [$];

    result_t expected_beats [$];

    function automatic int find_change(input logic [4:0] t);
        for (int i = 0; i < chg_task.size(); i++)
            if (chg_task[i] == t)
                return i;
        return -1;
    endfunction

    task automatic note_change(input logic [5:0] t, input logic [1:0] s);
        int k;
        logic [1:0] old;
        old = status[t];
        status[t] = s;
        k = find_change(t[4:0]);
        if (k >= 0)
        begin
            if (s == chg_prior[k])
            begin
                chg_task.delete(k);
                chg_state.delete(k);
                chg_prior.delete(k);
            end
            else
                chg_state[k] = s;
        end
        else
        begin
            chg_task.insert(chg_task.size(), t[4:0]);
            chg_state.insert(chg_state.size(), s);
            chg_prior.insert(chg_prior.size(), old);
        end
    endtask

    task automatic apply_item(input item_t it);
        logic [1:0] err;
        logic [5:0] t, p, n, b, c;
        int run;
        result_t r;
        err = ERR_OK;
        t = {1'b0, it.task_id};
        chg_task.delete();
        chg_state.delete();
        chg_prior.delete();
        if (it.kind == KIND_APPEND)
        begin
            if (t >= NTASK)
                err = ERR_ABSENT;
            else if (status[t] != ST_GONE)
                err = ERR_PRESENT;
            else
            begin
                prv[t] = tail_q;
                nxt[t] = NIL_LINK;
                if (tail_q != NIL_LINK)
                    nxt[tail_q] = t;
                else
                    head_q = t;
                tail_q = t;
                total_q++;
                if (bnd_q != NIL_LINK)
                    note_change(t, ST_THR);
                else if (total_q > limit_q)
                begin
                    bnd_q = t;
                    note_change(t, ST_THR);
                end
                else
                begin
                    note_change(t, ST_RUN);
                    run_q++;
                end
            end
        end
        else if (it.kind == KIND_REMOVE)
        begin
            if (t >= NTASK || status[t] == ST_GONE)
                err = ERR_ABSENT;
            else
            begin
                p = prv[t];
                n = nxt[t];
                if (p != NIL_LINK)
                    nxt[p] = n;
                else
                    head_q = n;
                if (n != NIL_LINK)
                    prv[n] = p;
                else
                    tail_q = p;
                total_q--;
                if (status[t] == ST_RUN)
                begin
                    if (bnd_q != NIL_LINK)
                    begin
                        b = bnd_q;
                        note_change(b, ST_RUN);
                        bnd_q = nxt[b];
                    end
                    else if (run_q > 0)
                        run_q--;
                end
                else if (t == bnd_q)
                    bnd_q = n;
                note_change(t, ST_GONE);
            end
        end
        run = run_q;
        while (run < limit_q && bnd_q != NIL_LINK)
        begin
            c = bnd_q;
            note_change(c, ST_RUN);
            bnd_q = nxt[c];
            run++;
        end
        while (run > limit_q)
        begin
            c = (bnd_q == NIL_LINK) ? tail_q : prv[bnd_q];
            if (c == NIL_LINK)
                break;
            bnd_q = c;
            note_change(c, ST_THR);
            run--;
        end
        run_q = run[5:0];
        for (int i = 0; i < chg_task.size(); i++)
        begin
            r = '0;
            r.notice_task = chg_task[i];
            r.new_state = chg_state[i];
            r.running_count = run_q;
            r.throttled_count = total_q - run_q;
            expected_beats.insert(expected_beats.size(), r);
        end
        r = '0;
        r.notice_task = it.task_id;
        r.is_summary = 1'b1;
        r.running_count = run_q;
        r.throttled_count = total_q - run_q;
        r.error_code = err;
        r.last = 1'b1;
        expected_beats.insert(expected_beats.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            limit_q = 6'd32;
            for (int i = 0; i < 64; i++)
            begin
                status[i] = ST_GONE;
                nxt[i] = '0;
                prv[i] = '0;
            end
            head_q = NIL_LINK;
            tail_q = NIL_LINK;
            bnd_q = NIL_LINK;
            run_q = '0;
            total_q = '0;
            expected_beats.delete();
            errors = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat %p", $time, result);
                end
                else
                begin
                    e = expected_beats[0];
                    expected_beats.delete(0);
                    if (result !== e)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, result);
                    end
                end
            end
            if (cfg_we)
                limit_q = cfg_wdata;
            if (start && !busy)
                apply_item(item);
        end
        pending = expected_beats.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives append, remove, rebalance and spare items into the admission throttle
// across several running limits, with random sender gaps and a full drain
// before each limit write; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import oat_pkg::*;

    localparam logic [1:0] KIND_REBAL = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    item_t      item = '0;
    logic       cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;
    logic       result_strobe;
    result_t    result;
    int         errors;
    int         pending;
    int         cycles = 0;
    bit         gaps_on = 1'b1;

    always #10 clk = ~clk;

    ordered_admission_throttle_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_strobe(result_strobe), .result(result)
    );

    oat_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_strobe(result_strobe), .result(result),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // start stays high from one item to the next unless a gap is taken
    task automatic send_item(input logic [1:0] k, input logic [4:0] t);
        if (gaps_on)
            while ($urandom_range(99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        item <= '{kind: k, task_id: t};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_item(KIND_APPEND, 5'($urandom_range(31)));
            else if (r < 88)
                send_item(KIND_REMOVE, 5'($urandom_range(31)));
            else if (r < 96)
                send_item(KIND_REBAL, 5'($urandom_range(31)));
            else
                send_item(KIND_SPARE, 5'($urandom_range(31)));
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(KIND_APPEND, 5'd0);
        send_item(KIND_APPEND, 5'd31);
        send_item(KIND_APPEND, 5'd0);
        send_item(KIND_REMOVE, 5'd7);
        send_item(KIND_REBAL, 5'd21);
        send_item(KIND_SPARE, 5'd10);
        write_limit(6'd1);
        send_item(KIND_REBAL, 5'd0);
        send_item(KIND_APPEND, 5'd3);
        send_item(KIND_APPEND, 5'd12);
        send_item(KIND_REMOVE, 5'd0);
        send_item(KIND_REMOVE, 5'd12);
        write_limit(6'd0);
        send_item(KIND_REBAL, 5'd0);
        send_item(KIND_APPEND, 5'd9);
        send_item(KIND_REMOVE, 5'd31);
        write_limit(6'd63);
        send_item(KIND_REBAL, 5'd0);
        for (int i = 0; i < 32; i++)
            send_item(KIND_APPEND, i[4:0]);
        write_limit(6'd2);
        send_item(KIND_REBAL, 5'd0);
        write_limit(6'd32);
        send_item(KIND_REBAL, 5'd0);
        write_limit(6'd5);
        random_phase(60);
        gaps_on = 1'b0;
        random_phase(40);
        gaps_on = 1'b1;
        write_limit(6'd0);
        random_phase(40);
        write_limit(6'd32);
        random_phase(30);
        write_limit(6'($urandom_range(1, 31)));
        random_phase(50);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
